// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication from one cycle to the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pmps_pkg.sv =====
// ---------------------------------------------------------------------------
// pmps_pkg
// Types and constants shared by the priority scheduler modules.
// ---------------------------------------------------------------------------
package pmps_pkg;

  localparam int unsigned TAG_W   = 8;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = TAG_W + BURST_W + TIME_W;

  // Request function codes
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_IDLE   = 2'd2;
  localparam logic [1:0] ST_RAN    = 2'd3;

  typedef struct packed {
    logic               func;
    logic [TAG_W-1:0]   task_tag;
    logic [LEVEL_W-1:0] level;
    logic [BURST_W-1:0] burst;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TAG_W-1:0]  running_tag;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] now;
  } out_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  arrival;
  } slot_t;

  // Controller to datapath commands
  typedef struct packed {
    logic decide;   // evaluate request, update queue state, issue store ops
    logic finish;   // take popped entry, run tick, load result register
  } pmps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_read; // decided request popped a store entry
  } pmps_sts_t;

endpackage

// ===== hw/rtl/pmps_ram.sv =====
// ---------------------------------------------------------------------------
// pmps_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pmps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pmps_ctrl.sv =====
// ---------------------------------------------------------------------------
// pmps_ctrl
// Request sequencer: accept, decide, optional store read, result hold.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmps_ctrl
  import pmps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pmps_cmd_t cmd,
  input  pmps_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  // Ready when idle, or when the held result leaves this cycle
  assign in_ready  = (state_r == S_IDLE) || (state_r == S_HOLD && out_ready);
  assign out_valid = (state_r == S_HOLD);
  assign acc       = in_valid && in_ready;

  assign cmd.decide = acc;
  assign cmd.finish = (state_r == S_READ) || (acc && !sts.need_read);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) state_nxt = sts.need_read ? S_READ : S_HOLD;
      end
      S_READ: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (acc) state_nxt = sts.need_read ? S_READ : S_HOLD;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_ALWAYS(a_state_legal, clk, rst_n, state_r != 2'd3, "illegal state")
  `ASSERT_NEXT(a_read_then_hold, clk, rst_n, state_r == S_READ, state_r == S_HOLD,
    "read not followed by result")
  `ASSERT_ALWAYS(a_one_cmd, clk, rst_n, !(cmd.decide && state_r == S_READ),
    "decide during read")

endmodule

// ===== hw/rtl/pmps_dp.sv =====
// ---------------------------------------------------------------------------
// pmps_dp
// Queue state, running task, time counter, entry store and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmps_dp
  import pmps_pkg::*;
#(
  parameter int unsigned LEVELS      = 10,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_data,
  output out_req_t  out_data,
  input  pmps_cmd_t cmd,
  output pmps_sts_t sts
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned AW = $clog2(LEVELS * QUEUE_DEPTH);

  logic [QW-1:0] head_r  [LEVELS];
  logic [CW-1:0] count_r [LEVELS];
  logic          run_v_r;
  slot_t         run_r;
  logic [LW-1:0] run_lvl_r;
  logic [TIME_W-1:0] time_r;
  out_req_t      res_r;

  // Decide-phase captures for the finish phase
  logic          pend_arr_r, pend_drop_r, pend_pop_r;
  slot_t         pend_run_r;
  logic          pend_run_v_r;

  // Combinational decision
  logic          is_arr, lvl_ok, drop;
  logic [LW-1:0] alv;
  logic          any;
  logic [LW-1:0] best;
  logic          pop, preempt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wslot, rslot;

  assign is_arr = (in_data.func == FUNC_ARRIVE);
  assign lvl_ok = (in_data.level != '0) &&
                  ({1'b0, in_data.level} <= (LEVEL_W + 1)'(LEVELS));
  assign alv    = LW'(in_data.level - LEVEL_W'(1));
  assign drop   = !lvl_ok || (count_r[alv] == CW'(QUEUE_DEPTH));

  // Best non-empty level: priority encoder over narrow flags
  always_comb begin
    any  = 1'b0;
    best = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0) begin
        any  = 1'b1;
        best = LW'(i);
      end
    end
  end

  assign preempt = run_v_r && any && (best < run_lvl_r) &&
                   (count_r[run_lvl_r] != CW'(QUEUE_DEPTH));
  assign pop     = !is_arr && any && (!run_v_r || preempt);
  assign sts.need_read = pop;

  function automatic logic [AW-1:0] addr_of(logic [LW-1:0] l, logic [QW-1:0] p);
    logic [AW:0] a;
    a = (AW + 1)'(l) * (AW + 1)'(QUEUE_DEPTH) + (AW + 1)'(p);
    return a[AW-1:0];
  endfunction

  function automatic logic [QW-1:0] wrap_add(logic [QW-1:0] h, logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(c);
    if (s >= (CW + 1)'(QUEUE_DEPTH)) s = s - (CW + 1)'(QUEUE_DEPTH);
    return s[QW-1:0];
  endfunction

  // Store write: arrival push or preempted task push
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wslot = '0;
    if (cmd.decide && is_arr && !drop) begin
      we    = 1'b1;
      waddr = addr_of(alv, wrap_add(head_r[alv], count_r[alv]));
      wslot.tag       = in_data.task_tag;
      wslot.remaining = (in_data.burst == '0) ? BURST_W'(1) : in_data.burst;
      wslot.arrival   = time_r;
    end else if (cmd.decide && preempt && !is_arr) begin
      we    = 1'b1;
      waddr = addr_of(run_lvl_r, wrap_add(head_r[run_lvl_r], count_r[run_lvl_r]));
      wslot = run_r;
    end
  end
  assign raddr = addr_of(best, head_r[best]);

  pmps_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS * QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wslot),
    .re    (cmd.decide && pop),
    .raddr (raddr),
    .rdata (rslot)
  );

  // Queue state and decide capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
      run_lvl_r <= '0;
    end else if (cmd.decide) begin
      if (is_arr) begin
        if (!drop) count_r[alv] <= count_r[alv] + CW'(1);
      end else if (pop) begin
        head_r[best] <= (head_r[best] == QW'(QUEUE_DEPTH - 1)) ? '0
                        : head_r[best] + QW'(1);
        if (preempt) begin
          // preempted level gains one, best loses one (distinct levels)
          count_r[run_lvl_r] <= count_r[run_lvl_r] + CW'(1);
        end
        count_r[best] <= count_r[best] - CW'(1);
        run_lvl_r     <= best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      pend_arr_r   <= is_arr;
      pend_drop_r  <= drop;
      pend_pop_r   <= pop;
      pend_run_r   <= run_r;
      pend_run_v_r <= run_v_r;
    end
  end

  // Finish phase: same-cycle when no pop, else on the cycle after decide
  logic          f_arr, f_drop, f_pop, f_rv;
  slot_t         f_run, cur;
  slot_t         run_nxt;
  logic [BURST_W-1:0] rem;
  out_req_t      res_nxt;
  logic          fin;

  assign f_arr  = cmd.decide ? is_arr  : pend_arr_r;
  assign f_drop = cmd.decide ? drop    : pend_drop_r;
  assign f_pop  = cmd.decide ? pop     : pend_pop_r;
  assign f_run  = cmd.decide ? run_r   : pend_run_r;
  assign f_rv   = cmd.decide ? run_v_r : pend_run_v_r;
  assign cur    = f_pop ? rslot : f_run;
  assign rem    = cur.remaining - BURST_W'(1);
  assign fin    = (rem == '0);

  // Served task with one tick of service taken off
  always_comb begin
    run_nxt           = cur;
    run_nxt.remaining = rem;
  end

  // Time has already advanced when a tick finishes in the read state, not at its decide
  always_comb begin
    res_nxt     = '0;
    res_nxt.now = (f_arr || cmd.decide) ? time_r : time_r - TIME_W'(1);
    if (f_arr) begin
      res_nxt.status = f_drop ? ST_DROP : ST_ACCEPT;
    end else if (f_pop || f_rv) begin
      res_nxt.status      = ST_RAN;
      res_nxt.running_tag = cur.tag;
      res_nxt.finished    = fin;
      res_nxt.turnaround  = fin ? res_nxt.now + TIME_W'(1) - cur.arrival : '0;
    end else begin
      res_nxt.status = ST_IDLE;
    end
  end

  // Running task, time counter, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_v_r <= 1'b0;
      run_r   <= '0;
      time_r  <= '0;
    end else begin
      if (cmd.decide && !is_arr) time_r <= time_r + TIME_W'(1);
      if (cmd.finish && !f_arr && (f_pop || f_rv)) begin
        run_v_r <= !fin;
        run_r   <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) res_r <= res_nxt;
  end

  assign out_data = res_r;

  `ASSERT_ALWAYS(a_pop_nonempty, clk, rst_n, !(cmd.decide && pop) || any,
    "pop from empty levels")
  `ASSERT_ALWAYS(a_preempt_better, clk, rst_n, !preempt || (best != run_lvl_r),
    "preempt into same level")
  `ASSERT_NEXT(a_tick_time, clk, rst_n, cmd.decide && !is_arr,
    time_r == $past(time_r) + TIME_W'(1), "tick did not advance time")

endmodule

// ===== hw/rtl/preemptive_multilevel_priority_scheduler.sv =====
// ---------------------------------------------------------------------------
// preemptive_multilevel_priority_scheduler
// Ten-level preemptive FIFO scheduler with turnaround reporting.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    in_data  (in_req_t)
// out_     out  out_valid/out_ready  out_data (out_req_t)
//
// Arrivals and ticks that pop nothing load the result register at decide;
// ticks that take a queue head load it after the registered read of the
// entry store. A new request is taken in the cycle its predecessor's result
// leaves. Synchronous active-low reset empties all levels, clears the
// running task and time; no clearing pass. out_ready low holds the result.
// ---------------------------------------------------------------------------
module preemptive_multilevel_priority_scheduler
  import pmps_pkg::*;
#(
  parameter int unsigned LEVELS      = 10,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  pmps_cmd_t cmd;
  pmps_sts_t sts;

  pmps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pmps_dp #(.LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
